// ===== hdl/cplru_pkg.sv =====
// ----------------------------------------------------------------------------
// cplru_pkg
// Shared constants and replacement tables for the four-way PLRU cache lookup.
// ----------------------------------------------------------------------------
package cplru_pkg;

  localparam int DEF_SETS      = 16;
  localparam int DEF_ADDR_BITS = 16;
  localparam int WAYS          = 4;
  localparam int WAY_IDX_W     = 2;
  localparam int OFFSET_BITS   = 3;
  localparam int PLRU_W        = 3;
  localparam int CNT_W         = 32;

  // victim way for each tree state
  localparam logic [WAY_IDX_W-1:0] VICTIM_OF_STATE [8] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
  };

  // next tree state, indexed by {state[1:0], accessed way}
  localparam logic [PLRU_W-1:0] PLRU_NEXT [16] = '{
    3'd6, 3'd4, 3'd1, 3'd0, 3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2, 3'd7, 3'd5, 3'd3, 3'd2
  };

endpackage

// ===== hdl/cplru_ifs.sv =====
// ----------------------------------------------------------------------------
// cplru_ifs
// Access and result channels of the PLRU cache lookup (valid/ready).
// ----------------------------------------------------------------------------
interface cplru_in_if
  import cplru_pkg::*;
#(
  parameter int ADDR_BITS = DEF_ADDR_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;
  logic                 is_write;

  modport source (output valid, output address, output is_write, input ready);
  modport sink   (input valid, input address, input is_write, output ready);
endinterface

interface cplru_out_if
  import cplru_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_IDX_W-1:0] way;
  logic                 write_back;
  logic [CNT_W-1:0]     read_count;
  logic [CNT_W-1:0]     write_count;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     miss_count;
  logic [CNT_W-1:0]     writeback_count;

  modport source (output valid, output hit, output way, output write_back,
                  output read_count, output write_count, output hit_count,
                  output miss_count, output writeback_count, input ready);
  modport sink   (input valid, input hit, input way, input write_back,
                  input read_count, input write_count, input hit_count,
                  input miss_count, input writeback_count, output ready);
endinterface

// ===== hdl/cplru_ram.sv =====
// ----------------------------------------------------------------------------
// cplru_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cplru_ram
  import cplru_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/four_way_cache_plru_lookup.sv =====
// ----------------------------------------------------------------------------
// four_way_cache_plru_lookup
// Tag-only four-way set-associative write-back cache with tree PLRU.
// ----------------------------------------------------------------------------
// Each access is accepted in the idle state, which starts the registered read of
// the set's row from the tag RAM, and is resolved in the lookup state: hit, fill
// and victim are found and the row is written back. An access is held in the
// lookup state while the previous result still sits unclaimed in the output
// register. The row holds valid, dirty and tag for all four ways plus the
// three PLRU bits. A flag per set marks rows written since reset, so an
// unwritten row reads as empty and no clearing pass follows reset. Statistics
// counters wrap at 2^32 and are reported with every result.
module four_way_cache_plru_lookup
  import cplru_pkg::*;
#(
  parameter int SETS      = DEF_SETS,
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  cplru_in_if.sink    in_chan,
  cplru_out_if.source out_chan
);

  localparam int IDX_W    = $clog2(SETS);
  localparam int TAG_RAW  = ADDR_BITS - OFFSET_BITS - IDX_W;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int ADDR_EXT = OFFSET_BITS + IDX_W + TAG_W;
  localparam int WAY_W    = TAG_W + 2;
  localparam int ROW_W    = WAYS * WAY_W + PLRU_W;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_LOOK = 1'b1;

  logic [0:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      idx_r;
  logic [TAG_W-1:0]      tag_r;
  logic                  wr_r;
  logic [SETS-1:0]       row_written_r;

  logic [ADDR_EXT-1:0]   addr_ext;
  logic [IDX_W-1:0]      in_idx;
  logic [TAG_W-1:0]      in_tag;
  logic                  in_xfer;
  logic                  commit;

  logic [ROW_W-1:0]      ram_rdata;
  logic [ROW_W-1:0]      row;
  logic [ROW_W-1:0]      row_new;
  logic [WAYS-1:0]       way_valid;
  logic [WAYS-1:0]       way_dirty;
  logic [WAYS-1:0]       way_match;
  logic [PLRU_W-1:0]     plru;
  logic [WAY_IDX_W-1:0]  hit_way;
  logic [WAY_IDX_W-1:0]  free_way;
  logic [WAY_IDX_W-1:0]  sel;
  logic                  hit;
  logic                  wb;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [WAY_IDX_W-1:0]  out_way_r;
  logic                  out_wb_r;
  logic [CNT_W-1:0]      cnt_rd_r, cnt_wr_r, cnt_hit_r, cnt_miss_r, cnt_wb_r;

  // index and tag; bits above the address width read as zero
  assign addr_ext = ADDR_EXT'(in_chan.address);
  assign in_idx   = addr_ext[OFFSET_BITS +: IDX_W] & IDX_W'(SETS - 1);
  assign in_tag   = addr_ext[ADDR_EXT-1 -: TAG_W];

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign commit        = (state_r == S_LOOK) && (!out_valid_r || out_chan.ready);

  cplru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (idx_r),
    .wdata (row_new),
    .re    (in_xfer),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    row  = row_written_r[idx_r] ? ram_rdata : '0;
    plru = row[ROW_W-1 -: PLRU_W];
    for (int w = 0; w < WAYS; w++) begin
      way_valid[w] = row[w*WAY_W + TAG_W + 1];
      way_dirty[w] = row[w*WAY_W + TAG_W];
      way_match[w] = way_valid[w] && (row[w*WAY_W +: TAG_W] == tag_r);
    end
    hit      = |way_match;
    hit_way  = '0;
    free_way = '0;
    // lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (way_match[w]) begin
        hit_way = WAY_IDX_W'(w);
      end
      if (!way_valid[w]) begin
        free_way = WAY_IDX_W'(w);
      end
    end
    if (hit) begin
      sel = hit_way;
    end else if (&way_valid) begin
      sel = VICTIM_OF_STATE[plru];
    end else begin
      sel = free_way;
    end
    wb = !hit && way_valid[sel] && way_dirty[sel];

    row_new = row;
    for (int w = 0; w < WAYS; w++) begin
      if (sel == WAY_IDX_W'(w)) begin
        if (!hit) begin
          row_new[w*WAY_W +: WAY_W] = {1'b1, 1'b0, tag_r};
        end
        if (wr_r) begin
          row_new[w*WAY_W + TAG_W] = 1'b1;
        end
      end
    end
    row_new[ROW_W-1 -: PLRU_W] = PLRU_NEXT[{plru[1:0], sel}];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      row_written_r <= '0;
      out_valid_r   <= 1'b0;
      cnt_rd_r      <= '0;
      cnt_wr_r      <= '0;
      cnt_hit_r     <= '0;
      cnt_miss_r    <= '0;
      cnt_wb_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        row_written_r[idx_r] <= 1'b1;
        out_valid_r          <= 1'b1;
        cnt_rd_r             <= cnt_rd_r + CNT_W'(!wr_r);
        cnt_wr_r             <= cnt_wr_r + CNT_W'(wr_r);
        cnt_hit_r            <= cnt_hit_r + CNT_W'(hit);
        cnt_miss_r           <= cnt_miss_r + CNT_W'(!hit);
        cnt_wb_r             <= cnt_wb_r + CNT_W'(wb);
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx_r <= in_idx;
      tag_r <= in_tag;
      wr_r  <= in_chan.is_write;
    end
    if (commit) begin
      out_hit_r <= hit;
      out_way_r <= sel;
      out_wb_r  <= wb;
    end
  end

  // counters only move on commit, so they double as the result payload
  assign out_chan.valid           = out_valid_r;
  assign out_chan.hit             = out_hit_r;
  assign out_chan.way             = out_way_r;
  assign out_chan.write_back      = out_wb_r;
  assign out_chan.read_count      = cnt_rd_r;
  assign out_chan.write_count     = cnt_wr_r;
  assign out_chan.hit_count       = cnt_hit_r;
  assign out_chan.miss_count      = cnt_miss_r;
  assign out_chan.writeback_count = cnt_wb_r;

  a_accept_then_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_LOOK))
    else $error("accepted access did not move to lookup");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (state_r == S_LOOK))
    else $error("tag RAM written outside lookup");

  a_hold_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> $stable(cnt_hit_r) && $stable(cnt_miss_r))
    else $error("counters moved while a result was held");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_wb_r))
    else $error("write-back reported on a hit");

  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_rd_r + cnt_wr_r) == (cnt_hit_r + cnt_miss_r))
    else $error("access count differs from hit plus miss count");

endmodule

// ===== verif/cplru_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// cplru_lookup_checker
// Watches the access and result channels of the PLRU cache lookup, keeps its
// own tag, valid, dirty, tree and counter state, and compares every result
// transfer field by field with the oldest predicted lookup.
// ----------------------------------------------------------------------------
module cplru_lookup_checker
  import cplru_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  cplru_in_if   in_mon,
  cplru_out_if  out_mon,
  output int    fail_count,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W = DEF_ADDR_BITS;
  localparam int SET_W  = $clog2(DEF_SETS);
  localparam int TAG_W  = ADDR_W - OFFSET_BITS - SET_W;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] way;
    logic                 write_back;
    logic [CNT_W-1:0]     read_count;
    logic [CNT_W-1:0]     write_count;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
    logic [CNT_W-1:0]     writeback_count;
  } lookup_result_t;

  // shadow cache
  logic [PLRU_W-1:0] tree_bits [DEF_SETS];
  logic              way_valid [WAYS][DEF_SETS];
  logic              way_dirty [WAYS][DEF_SETS];
  logic [TAG_W-1:0]  way_tag   [WAYS][DEF_SETS];
  logic [CNT_W-1:0]  n_reads, n_writes, n_hits, n_misses, n_wbs;

  lookup_result_t lookups_due [$];
  int n_fail = 0;
  int n_due  = 0;
  int n_seen = 0;

  assign fail_count  = n_fail;
  assign outstanding = n_due;

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    n_fail++;
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0h, expected %0h",
                             n_seen, name, got, want));
  endtask

  task automatic clear_cache();
    foreach (tree_bits[s]) tree_bits[s] = '0;
    foreach (way_valid[w, s]) begin
      way_valid[w][s] = 1'b0;
      way_dirty[w][s] = 1'b0;
      way_tag[w][s]   = '0;
    end
    n_reads  = '0;
    n_writes = '0;
    n_hits   = '0;
    n_misses = '0;
    n_wbs    = '0;
  endtask

  task automatic predict_lookup(input logic [ADDR_W-1:0] addr, input logic wr,
                                output lookup_result_t r);
    logic [SET_W-1:0]     s;
    logic [TAG_W-1:0]     t;
    logic [WAY_IDX_W-1:0] sel;
    logic [PLRU_W-1:0]    st;
    logic                 is_hit, wb;
    s      = addr[OFFSET_BITS +: SET_W];
    t      = addr[ADDR_W-1 -: TAG_W];
    is_hit = 1'b0;
    wb     = 1'b0;
    sel    = '0;
    if (wr) n_writes++;
    else    n_reads++;
    // descending scan, so the lowest matching way wins
    for (int w = WAYS - 1; w >= 0; w--)
      if (way_valid[w][s] && way_tag[w][s] == t) begin
        is_hit = 1'b1;
        sel    = WAY_IDX_W'(w);
      end
    if (is_hit) begin
      n_hits++;
    end else begin
      n_misses++;
      st  = tree_bits[s];
      sel = st[2] ? {1'b1, st[0]} : {1'b0, st[1]};
      // an empty way takes precedence over the tree's choice
      for (int w = WAYS - 1; w >= 0; w--)
        if (!way_valid[w][s]) sel = WAY_IDX_W'(w);
      if (way_valid[sel][s] && way_dirty[sel][s]) begin
        wb = 1'b1;
        n_wbs++;
      end
      way_valid[sel][s] = 1'b1;
      way_dirty[sel][s] = 1'b0;
      way_tag[sel][s]   = t;
    end
    // point away from the accessed way, keep the other pair's bit
    st = tree_bits[s];
    tree_bits[s] = sel[1] ? {1'b0, st[1], ~sel[0]} : {1'b1, ~sel[0], st[0]};
    if (wr) way_dirty[sel][s] = 1'b1;
    r.hit             = is_hit;
    r.way             = sel;
    r.write_back      = wb;
    r.read_count      = n_reads;
    r.write_count     = n_writes;
    r.hit_count       = n_hits;
    r.miss_count      = n_misses;
    r.writeback_count = n_wbs;
  endtask

  initial clear_cache();

  always @(posedge clk) begin
    lookup_result_t due;
    if (!rst_n) begin
      clear_cache();
      lookups_due.delete();
    end else begin
      // result side first: a transfer never belongs to this edge's access
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (lookups_due.size() == 0) begin
          report_error($sformatf("result %0d with no access outstanding", n_seen));
        end else begin
          due = lookups_due.pop_front();
          check_field("hit",             out_mon.hit,             due.hit);
          check_field("way",             out_mon.way,             due.way);
          check_field("write_back",      out_mon.write_back,      due.write_back);
          check_field("read_count",      out_mon.read_count,      due.read_count);
          check_field("write_count",     out_mon.write_count,     due.write_count);
          check_field("hit_count",       out_mon.hit_count,       due.hit_count);
          check_field("miss_count",      out_mon.miss_count,      due.miss_count);
          check_field("writeback_count", out_mon.writeback_count,
                      due.writeback_count);
        end
        n_seen++;
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        predict_lookup(in_mon.address, in_mon.is_write, due);
        lookups_due.push_back(due);
      end
    end
    n_due <= lookups_due.size();
  end

endmodule

// ===== verif/tb_four_way_cache_plru_lookup.sv =====
// ----------------------------------------------------------------------------
// tb_four_way_cache_plru_lookup
// Drives directed and random cache accesses into the PLRU lookup in bursts,
// stalls the result side on a shifting pattern with one long hold-off, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_four_way_cache_plru_lookup
  import cplru_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W       = DEF_ADDR_BITS;
  localparam int RANDOM_ITEMS = 1430;
  localparam int HOLD_AFTER   = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  // {is_write, address}
  localparam logic [ADDR_W:0] DIRECTED [21] = '{
    {1'b1, 16'h0000}, {1'b0, 16'h0000}, {1'b0, 16'h0080}, {1'b1, 16'h0104},
    {1'b0, 16'h0187}, {1'b0, 16'h0200}, {1'b1, 16'h0280}, {1'b0, 16'h0300},
    {1'b0, 16'h0380}, {1'b0, 16'h0000}, {1'b1, 16'hFFFF}, {1'b0, 16'hFFF8},
    {1'b1, 16'h7F78}, {1'b1, 16'h8078}, {1'b1, 16'h00F8}, {1'b0, 16'h0F78},
    {1'b0, 16'h1F78}, {1'b1, 16'hFFFF}, {1'b0, 16'h0040}, {1'b1, 16'h0040},
    {1'b0, 16'h0047}
  };

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count, outstanding;
  int   items_sent = 0;
  int   burst_left = 0;
  int   cycles     = 0;
  bit   hold_done  = 1'b0;

  cplru_in_if #(.ADDR_BITS(ADDR_W)) in_if ();
  cplru_out_if                      out_if ();

  four_way_cache_plru_lookup i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  cplru_lookup_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // sender: bursts of random length, random gaps, junk payload while idle
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic wr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid    <= 1'b0;
        in_if.address  <= ADDR_W'($urandom);
        in_if.is_write <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.address  <= addr;
    in_if.is_write <= wr;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  task automatic run_random();
    logic [8:0]        tag_pool [6];
    logic [3:0]        hot_set;
    logic [ADDR_W-1:0] addr, last_addr;
    int                pick;
    last_addr = '0;
    hot_set   = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) begin
        foreach (tag_pool[k]) tag_pool[k] = 9'($urandom);
        hot_set = 4'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        addr = last_addr;                    // same set back to back
      end else if (pick < 8) begin
        // small working set of tags over a few sets: hits and evictions
        addr = {tag_pool[$urandom_range(0, 5)], 4'(hot_set + $urandom_range(0, 2)),
                3'($urandom)};
      end else begin
        addr = ADDR_W'($urandom);
      end
      send_access(addr, $urandom_range(0, 2) == 0);
      last_addr = addr;
    end
  endtask

  // receiver: segments of different stall patterns, one long hold-off
  initial begin
    int seg, mode;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 60);
      repeat (seg) begin
        case (mode)
          0: begin
            out_if.ready <= 1'b1;
          end
          1: begin
            out_if.ready <= 1'($urandom);
          end
          2: begin
            out_if.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_if.ready <= ~out_if.ready;
          end
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    in_if.valid    <= 1'b0;
    in_if.address  <= '0;
    in_if.is_write <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    foreach (DIRECTED[i]) send_access(DIRECTED[i][ADDR_W-1:0], DIRECTED[i][ADDR_W]);
    run_random();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
